[src/gte_pkg.sv]
`default_nettype none

package gte_pkg;

  // field widths
  localparam int unsigned ANG_W   = 32;
  localparam int unsigned H_W     = 27;
  localparam int unsigned OUT_W   = 35;
  localparam int unsigned TRIG_W  = 32;
  localparam int unsigned LEN_W   = 36;
  localparam int unsigned MF_W    = 40;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // pipeline shape
  localparam int unsigned CORDIC_STAGES    = 28;
  localparam int unsigned CORDIC_PER_STAGE = 2;
  localparam int unsigned CORDIC_REGS      = CORDIC_STAGES / CORDIC_PER_STAGE;
  localparam int unsigned SQRT_STEPS       = 32;
  localparam int unsigned SQRT_PER_STAGE   = 2;
  localparam int unsigned SQRT_REGS        = SQRT_STEPS / SQRT_PER_STAGE;
  localparam int unsigned QUOT_W           = 34;
  localparam int unsigned DIV_PER_STAGE    = 2;
  localparam int unsigned DIV_REGS         = QUOT_W / DIV_PER_STAGE;
  localparam int unsigned SIDE_LEN         = 5 + SQRT_REGS + DIV_REGS + 3;
  localparam int unsigned ECEF_LAT         = 1 + CORDIC_REGS + SIDE_LEN;
  localparam int unsigned ROT_LAT          = 5;
  localparam int unsigned PIPE_LAT         = ECEF_LAT + ROT_LAT;

  // ellipsoid constants
  localparam logic [63:0] SEMI_MAJOR_DMM = 64'd63781370000;
  localparam logic [63:0] SEMI_MINOR_DMM = 64'd63567523142;
  localparam logic [63:0] SEMI_MAJOR_MM  = 64'd6378137000;
  localparam logic [63:0] DIV_NUM        = SEMI_MAJOR_MM << 31;

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_LAT   = 2'd0,
    CFG_ORIGIN_LON   = 2'd1,
    CFG_ORIGIN_H     = 2'd2,
    CFG_ORIGIN_VALID = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cp;
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] cl;
    logic signed [TRIG_W-1:0] sl;
  } trig_t;

  // (b/a)^2 in Q60: restoring division to Q62, then squared with truncation
  function automatic logic [59:0] calc_r2();
    logic [63:0]  q;
    logic [63:0]  rem;
    logic [127:0] sq;
    q   = '0;
    rem = SEMI_MINOR_DMM;
    if (rem >= SEMI_MAJOR_DMM) begin
      q   = 64'd1;
      rem = rem - SEMI_MAJOR_DMM;
    end
    for (int k = 0; k < 62; k++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= SEMI_MAJOR_DMM) begin
        rem = rem - SEMI_MAJOR_DMM;
        q   = q | 64'd1;
      end
    end
    sq = 128'(q) * 128'(q);
    return sq[123:64];
  endfunction

  localparam logic [59:0] R2    = calc_r2();
  localparam logic [29:0] R2_LO = R2[29:0];
  localparam logic [29:0] R2_HI = R2[59:30];

  // length times q30 fraction, rounded half up
  function automatic logic signed [MF_W-1:0] mul_frac(input logic signed [MF_W-1:0] a,
                                                      input logic signed [TRIG_W-1:0] f);
    logic signed [MF_W+TRIG_W-1:0] p;
    p = (MF_W+TRIG_W)'(a) * (MF_W+TRIG_W)'(f);
    p = p + (MF_W+TRIG_W)'(64'd536870912);
    return p[MF_W+29:30];
  endfunction

endpackage

`default_nettype wire

[src/gte_if.sv]
`default_nettype none

// input channel: one geodetic point per transaction
interface gte_in_if;
  import gte_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] point_latitude;
  logic signed [ANG_W-1:0] point_longitude;
  logic signed [H_W-1:0]   point_height;
  logic                    point_valid;

  modport source (output valid, point_latitude, point_longitude, point_height, point_valid,
                  input ready);
  modport sink (input valid, point_latitude, point_longitude, point_height, point_valid,
                output ready);
endinterface

// output channel: one local offset per transaction
interface gte_out_if;
  import gte_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] east_offset;
  logic signed [OUT_W-1:0] north_offset;
  logic signed [OUT_W-1:0] up_offset;
  logic                    result_valid;

  modport source (output valid, east_offset, north_offset, up_offset, result_valid,
                  input ready);
  modport sink (input valid, east_offset, north_offset, up_offset, result_valid,
                output ready);
endinterface

`default_nettype wire

[src/gte_ecef.sv]
`default_nettype none

module gte_ecef (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [gte_pkg::ANG_W-1:0] lat_i,
  input  logic signed [gte_pkg::ANG_W-1:0] lon_i,
  input  logic signed [gte_pkg::H_W-1:0]   h_i,
  output logic signed [gte_pkg::LEN_W-1:0] x_o,
  output logic signed [gte_pkg::LEN_W-1:0] y_o,
  output logic signed [gte_pkg::LEN_W-1:0] z_o,
  output gte_pkg::trig_t                   trig_o
);
  import gte_pkg::*;

  localparam int unsigned CX_W = 44;
  localparam logic signed [CX_W-1:0] CORDIC_X0 = 44'sd667681662976;
  localparam logic signed [CX_W-1:0] CX_ROUND  = 44'sd512;
  localparam logic signed [ANG_W-1:0] QUARTER  = 32'sd1073741824;

  // atan(2^-i), 2^32 units per turn
  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STAGES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5
  };

  typedef struct packed {
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sqrt_t;

  typedef struct packed {
    logic [32:0]       r;
    logic [QUOT_W-1:0] q;
    logic [31:0]       d;
  } div_t;

  typedef struct packed {
    logic signed [H_W-1:0] h;
    trig_t                 tr;
  } side_t;

  function automatic cordic_t cordic_step(input cordic_t c, input int unsigned i);
    cordic_t                r;
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (!c.z[ANG_W-1]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - ATAN_TAB[i];
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + ATAN_TAB[i];
    end
    return r;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t s, input int unsigned j);
    sqrt_t       o;
    logic [63:0] b;
    logic [64:0] sum;
    b   = 64'd1 << (62 - 2 * j);
    sum = {1'b0, s.r} + {1'b0, b};
    o   = s;
    if ({1'b0, s.n} >= sum) begin
      o.n = s.n - sum[63:0];
      o.r = (s.r >> 1) + b;
    end else begin
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic div_t div_step(input div_t v, input int unsigned j);
    div_t        o;
    logic [32:0] rr;
    rr = {v.r[31:0], DIV_NUM[QUOT_W-1-j]};
    o  = v;
    if (rr >= {1'b0, v.d}) begin
      o.r = rr - {1'b0, v.d};
      o.q = {v.q[QUOT_W-2:0], 1'b1};
    end else begin
      o.r = rr;
      o.q = {v.q[QUOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [ANG_W-1:0] ang [2];
  assign ang[0] = lat_i;
  assign ang[1] = lon_i;

  cordic_t               cs_q [CORDIC_REGS+1][2];
  logic [1:0]            cq_q [CORDIC_REGS+1][2];
  logic signed [H_W-1:0] ch_q [CORDIC_REGS+1];

  // fold angle into plus or minus an eighth turn, remember the quadrant
  cordic_t    c0_d [2];
  logic [1:0] q0_d [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      c0_d[a].x = CORDIC_X0;
      c0_d[a].y = '0;
      if (ang[a][ANG_W-3]) begin
        c0_d[a].z = $signed({2'b00, ang[a][ANG_W-3:0]}) - QUARTER;
        q0_d[a]   = ang[a][ANG_W-1:ANG_W-2] + 2'd1;
      end else begin
        c0_d[a].z = $signed({2'b00, ang[a][ANG_W-3:0]});
        q0_d[a]   = ang[a][ANG_W-1:ANG_W-2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs_q[0] <= c0_d;
      cq_q[0] <= q0_d;
      ch_q[0] <= h_i;
    end
  end

  // cordic rotator, two micro-rotations per register
  for (genvar s = 0; s < CORDIC_REGS; s++) begin : g_cordic
    cordic_t nx [2];
    always_comb begin
      for (int a = 0; a < 2; a++) begin
        nx[a] = cs_q[s][a];
        for (int k = 0; k < CORDIC_PER_STAGE; k++) begin
          nx[a] = cordic_step(nx[a], s * CORDIC_PER_STAGE + k);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cs_q[s+1] <= nx;
        cq_q[s+1] <= cq_q[s];
        ch_q[s+1] <= ch_q[s];
      end
    end
  end

  // round to q30 and apply quadrant
  logic signed [TRIG_W-1:0] cos_d [2];
  logic signed [TRIG_W-1:0] sin_d [2];
  always_comb begin
    logic signed [CX_W-1:0]   xt;
    logic signed [CX_W-1:0]   yt;
    logic signed [TRIG_W-1:0] xr;
    logic signed [TRIG_W-1:0] yr;
    for (int a = 0; a < 2; a++) begin
      xt = (cs_q[CORDIC_REGS][a].x + CX_ROUND) >>> 10;
      yt = (cs_q[CORDIC_REGS][a].y + CX_ROUND) >>> 10;
      xr = xt[TRIG_W-1:0];
      yr = yt[TRIG_W-1:0];
      case (cq_q[CORDIC_REGS][a])
        2'd0: begin cos_d[a] = xr;  sin_d[a] = yr;  end
        2'd1: begin cos_d[a] = -yr; sin_d[a] = xr;  end
        2'd2: begin cos_d[a] = -xr; sin_d[a] = -yr; end
        default: begin cos_d[a] = yr; sin_d[a] = -xr; end
      endcase
    end
  end

  // height and trig values travel beside the radius computation
  side_t side_q [SIDE_LEN];
  side_t side_d;
  always_comb begin
    side_d.h     = ch_q[CORDIC_REGS];
    side_d.tr.cp = cos_d[0];
    side_d.tr.sp = sin_d[0];
    side_d.tr.cl = cos_d[1];
    side_d.tr.sl = sin_d[1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_d;
      for (int k = 1; k < SIDE_LEN; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // squares of cos and sin of latitude
  logic [61:0] cpsq_q;
  logic [61:0] spsq_q;
  always_ff @(posedge clk_i) begin
    logic signed [63:0] cc;
    logic signed [63:0] ss;
    cc = 64'(side_q[0].tr.cp) * 64'(side_q[0].tr.cp);
    ss = 64'(side_q[0].tr.sp) * 64'(side_q[0].tr.sp);
    if (en_i) begin
      cpsq_q <= cc[61:0];
      spsq_q <= ss[61:0];
    end
  end

  // partial products of r2 times sin squared
  logic [60:0] pll_q, plh_q, phl_q, phh_q;
  logic [61:0] cpsq2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q   <= 61'(R2_LO) * 61'(spsq_q[30:0]);
      plh_q   <= 61'(R2_LO) * 61'(spsq_q[61:31]);
      phl_q   <= 61'(R2_HI) * 61'(spsq_q[30:0]);
      phh_q   <= 61'(R2_HI) * 61'(spsq_q[61:31]);
      cpsq2_q <= cpsq_q;
    end
  end

  // sum partials, keep the q60 integer part
  logic [61:0] rs_q;
  logic [61:0] cpsq3_q;
  always_ff @(posedge clk_i) begin
    logic [121:0] full;
    full = (122'(phh_q) << 61) + (122'(plh_q) << 31) + (122'(phl_q) << 30) + 122'(pll_q);
    if (en_i) begin
      rs_q    <= full[121:60];
      cpsq3_q <= cpsq2_q;
    end
  end

  // w with clamp, then 4w for the root
  logic [63:0] wv_q;
  always_ff @(posedge clk_i) begin
    logic [62:0] w;
    w = 63'(cpsq3_q) + 63'(rs_q);
    if (w > (63'd1 << 61)) begin
      w = 63'd1 << 61;
    end else if (w < (63'd1 << 59)) begin
      w = 63'd1 << 59;
    end
    if (en_i) begin
      wv_q <= {w[61:0], 2'b00};
    end
  end

  // integer square root, two steps per register
  sqrt_t sq_q [SQRT_REGS];
  for (genvar s = 0; s < SQRT_REGS; s++) begin : g_sqrt
    sqrt_t nx;
    always_comb begin
      if (s == 0) begin
        nx.n = wv_q;
        nx.r = '0;
      end else begin
        nx = sq_q[s == 0 ? 0 : s-1];
      end
      for (int k = 0; k < SQRT_PER_STAGE; k++) begin
        nx = sqrt_step(nx, s * SQRT_PER_STAGE + k);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[s] <= nx;
      end
    end
  end

  // radius of curvature: constant numerator over the root, two quotient bits per register
  div_t dv_q [DIV_REGS];
  for (genvar s = 0; s < DIV_REGS; s++) begin : g_div
    div_t nx;
    always_comb begin
      if (s == 0) begin
        nx.r = 33'(DIV_NUM[63:QUOT_W]);
        nx.q = '0;
        nx.d = sq_q[SQRT_REGS-1].r[31:0];
      end else begin
        nx = dv_q[s == 0 ? 0 : s-1];
      end
      for (int k = 0; k < DIV_PER_STAGE; k++) begin
        nx = div_step(nx, s * DIV_PER_STAGE + k);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[s] <= nx;
      end
    end
  end

  localparam int unsigned NB1_SIDE = 4 + SQRT_REGS + DIV_REGS;

  // n(1-e2) partials and n+h
  logic [63:0]             nbl_q, nbh_q;
  logic signed [LEN_W-1:0] a1_q;
  always_ff @(posedge clk_i) begin
    logic [QUOT_W-1:0] n;
    n = dv_q[DIV_REGS-1].q;
    if (en_i) begin
      nbl_q <= 64'(n) * 64'(R2_LO);
      nbh_q <= 64'(n) * 64'(R2_HI);
      a1_q  <= $signed({2'b00, n}) + LEN_W'(side_q[NB1_SIDE].h);
    end
  end

  // n(1-e2) and (n+h)cos(lat)
  logic [QUOT_W-1:0]       nb_q;
  logic signed [LEN_W-1:0] t_q;
  always_ff @(posedge clk_i) begin
    logic [93:0]            s;
    logic signed [MF_W-1:0] t;
    s = (94'(nbh_q) << 30) + 94'(nbl_q);
    t = mul_frac(MF_W'(a1_q), side_q[NB1_SIDE+1].tr.cp);
    if (en_i) begin
      nb_q <= s[93:60];
      t_q  <= t[LEN_W-1:0];
    end
  end

  // earth-centred coordinates
  logic signed [LEN_W-1:0] x_q, y_q, z_q;
  always_ff @(posedge clk_i) begin
    logic signed [LEN_W-1:0] zb;
    logic signed [MF_W-1:0]  xm;
    logic signed [MF_W-1:0]  ym;
    logic signed [MF_W-1:0]  zm;
    zb = $signed({2'b00, nb_q}) + LEN_W'(side_q[NB1_SIDE+2].h);
    xm = mul_frac(MF_W'(t_q), side_q[NB1_SIDE+2].tr.cl);
    ym = mul_frac(MF_W'(t_q), side_q[NB1_SIDE+2].tr.sl);
    zm = mul_frac(MF_W'(zb), side_q[NB1_SIDE+2].tr.sp);
    if (en_i) begin
      x_q <= xm[LEN_W-1:0];
      y_q <= ym[LEN_W-1:0];
      z_q <= zm[LEN_W-1:0];
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign trig_o = side_q[SIDE_LEN-1].tr;

endmodule

`default_nettype wire

[src/geodetic_to_enu.sv]
// throughput: one transaction per cycle; a stall on the output freezes every stage at once
// the depth comes from the cordic rotators (2 steps a stage), the square root (2 bits a stage)
// and the radius divider (2 quotient bits a stage)
// reset: valid bits cleared, origin registers cleared (origin marked undefined)
`default_nettype none

module geodetic_to_enu (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gte_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gte_pkg::CFG_W-1:0]          cfg_data_i,
  gte_in_if.sink                             pt_i,
  gte_out_if.source                          enu_o
);
  import gte_pkg::*;

  localparam logic signed [MF_W-1:0] OUT_MAX = 40'sd17179869183;
  localparam logic signed [MF_W-1:0] OUT_MIN = -40'sd17179869184;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [MF_W-1:0] v);
    logic signed [MF_W-1:0] t;
    t = v;
    if (v > OUT_MAX) begin
      t = OUT_MAX;
    end else if (v < OUT_MIN) begin
      t = OUT_MIN;
    end
    return t[OUT_W-1:0];
  endfunction

  // origin registers
  logic signed [ANG_W-1:0] org_lat_q, org_lon_q;
  logic signed [H_W-1:0]   org_h_q;
  logic                    org_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_lat_q   <= '0;
      org_lon_q   <= '0;
      org_h_q     <= '0;
      org_valid_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_LAT:   org_lat_q   <= cfg_data_i[ANG_W-1:0];
        CFG_ORIGIN_LON:   org_lon_q   <= cfg_data_i[ANG_W-1:0];
        CFG_ORIGIN_H:     org_h_q     <= cfg_data_i[H_W-1:0];
        CFG_ORIGIN_VALID: org_valid_q <= cfg_data_i[0];
      endcase
    end
  end

  // pipeline advance: every stage moves unless the result waits
  logic                adv;
  logic [PIPE_LAT-1:0] vld_q;
  logic [PIPE_LAT-1:0] ok_q;

  assign adv        = !vld_q[PIPE_LAT-1] || enu_o.ready;
  assign pt_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], pt_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_q <= {ok_q[PIPE_LAT-2:0], pt_i.point_valid & org_valid_q};
    end
  end

  // point and origin to earth-centred coordinates
  logic signed [LEN_W-1:0] px, py, pz, ox, oy, oz;
  trig_t                   org_tr;

  gte_ecef u_pt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .lat_i  (pt_i.point_latitude),
    .lon_i  (pt_i.point_longitude),
    .h_i    (pt_i.point_height),
    .x_o    (px),
    .y_o    (py),
    .z_o    (pz),
    .trig_o ()
  );

  gte_ecef u_org (
    .clk_i  (clk_i),
    .en_i   (adv),
    .lat_i  (org_lat_q),
    .lon_i  (org_lon_q),
    .h_i    (org_h_q),
    .x_o    (ox),
    .y_o    (oy),
    .z_o    (oz),
    .trig_o (org_tr)
  );

  // difference from origin
  logic signed [LEN_W:0] dx_q, dy_q, dz_q;
  trig_t                 tr0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q  <= (LEN_W+1)'(px) - (LEN_W+1)'(ox);
      dy_q  <= (LEN_W+1)'(py) - (LEN_W+1)'(oy);
      dz_q  <= (LEN_W+1)'(pz) - (LEN_W+1)'(oz);
      tr0_q <= org_tr;
    end
  end

  // rotate about the polar axis: products
  logic signed [MF_W-1:0] m_xc_q, m_ys_q, m_yc_q, m_xs_q;
  logic signed [LEN_W:0]  dz1_q;
  trig_t                  tr1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_xc_q <= mul_frac(MF_W'(dx_q), tr0_q.cl);
      m_ys_q <= mul_frac(MF_W'(dy_q), tr0_q.sl);
      m_yc_q <= mul_frac(MF_W'(dy_q), tr0_q.cl);
      m_xs_q <= mul_frac(MF_W'(dx_q), tr0_q.sl);
      dz1_q  <= dz_q;
      tr1_q  <= tr0_q;
    end
  end

  // horizontal projection and east
  logic signed [MF_W-1:0] proj_q, east_q;
  logic signed [LEN_W:0]  dz2_q;
  trig_t                  tr2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      proj_q <= m_xc_q + m_ys_q;
      east_q <= m_yc_q - m_xs_q;
      dz2_q  <= dz1_q;
      tr2_q  <= tr1_q;
    end
  end

  // tilt about the east axis: products
  logic signed [MF_W-1:0] m_zc_q, m_ps_q, m_pc_q, m_zs_q, east3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_zc_q  <= mul_frac(MF_W'(dz2_q), tr2_q.cp);
      m_ps_q  <= mul_frac(proj_q, tr2_q.sp);
      m_pc_q  <= mul_frac(proj_q, tr2_q.cp);
      m_zs_q  <= mul_frac(MF_W'(dz2_q), tr2_q.sp);
      east3_q <= east_q;
    end
  end

  // saturate and zero invalid results into the output register
  logic signed [OUT_W-1:0] out_e_q, out_n_q, out_u_q;
  logic                    out_ok_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ok_q <= ok_q[PIPE_LAT-2];
      if (ok_q[PIPE_LAT-2]) begin
        out_e_q <= sat_out(east3_q);
        out_n_q <= sat_out(m_zc_q - m_ps_q);
        out_u_q <= sat_out(m_pc_q + m_zs_q);
      end else begin
        out_e_q <= '0;
        out_n_q <= '0;
        out_u_q <= '0;
      end
    end
  end

  assign enu_o.valid        = vld_q[PIPE_LAT-1];
  assign enu_o.east_offset  = out_e_q;
  assign enu_o.north_offset = out_n_q;
  assign enu_o.up_offset    = out_u_q;
  assign enu_o.result_valid = out_ok_q;

`ifndef NO_ASSERTIONS
  // a waiting result holds back the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enu_o.valid && !enu_o.ready |-> !pt_i.ready)
    else $error("input accepted while result stalled");

  // an accepted transaction enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_i.valid && pt_i.ready |=> vld_q[0])
    else $error("accepted transaction missing from first stage");

  // a frozen pipeline keeps its valid bits
  a_freeze_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q))
    else $error("valid bits moved during stall");

  // undefined results carry zero offsets
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enu_o.valid && !enu_o.result_valid |->
      enu_o.east_offset == '0 && enu_o.north_offset == '0 && enu_o.up_offset == '0)
    else $error("undefined result with nonzero offsets");
`endif

endmodule

`default_nettype wire

[sim/tb_geodetic_to_enu.sv]
`default_nettype none

module tb_geodetic_to_enu;
  import gte_pkg::*;

  localparam int  WATCHDOG_LIMIT = 5000;
  localparam int  DRAIN_CYCLES   = 70;
  localparam int  RAND_PER_PHASE = 260;
  localparam longint LAT_MAX     = 64'sd1073741824;
  localparam longint H_LOW       = -64'sd500000;
  localparam longint H_HIGH      = 64'sd50000000;
  localparam longint OFS_MAX     = 64'sd17179869183;
  localparam longint OFS_MIN     = -64'sd17179869184;
  localparam longint GAIN_Q30    = 64'sd652032874;

  typedef struct {
    longint lat;
    longint lon;
    longint h;
    bit     pv;
    bit     typed;
    longint e;
    longint n;
    longint u;
    bit     rv;
  } point_row_t;

  typedef struct {
    logic signed [OUT_W-1:0] e;
    logic signed [OUT_W-1:0] n;
    logic signed [OUT_W-1:0] u;
    logic                    rv;
  } enu_exp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  gte_in_if  pt ();
  gte_out_if enu ();

  geodetic_to_enu dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pt_i       (pt),
    .enu_o      (enu)
  );

  // origin copy held by the predictor
  longint org_lat, org_lon, org_h;
  bit     org_valid;

  longint unsigned atan_units [40];
  longint unsigned axis_r2;

  enu_exp_t pending_enu [$];
  int     fail_cnt;
  int     idle_cycles;
  int     burst_left;
  int     rx_cnt;

  // clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // ---------------- predictor arithmetic ----------------

  function automatic longint unsigned hi_mul_shift(longint unsigned a, longint unsigned b,
                                                   int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic longint unsigned q62_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q, rem;
    q   = 0;
    rem = num;
    if (rem >= den) begin
      q   = 1;
      rem = rem - den;
    end
    for (int k = 0; k < 62; k++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // atan(1/k) in q62 by power series
  function automatic longint unsigned atan_inv(longint unsigned k);
    longint unsigned p, sum, n;
    p   = (64'd1 << 62) / k;
    sum = p;
    n   = 1;
    forever begin
      p = p / (k * k);
      if (p == 0) break;
      if (n[0]) sum = sum - p / (2 * n + 1);
      else sum = sum + p / (2 * n + 1);
      n++;
    end
    return sum;
  endfunction

  // atan(2^-i) in q62
  function automatic longint unsigned atan_shift(int i);
    longint unsigned sum, n, t;
    int sh;
    sum = 0;
    n   = 0;
    sh  = i;
    while (sh <= 62) begin
      t = ((64'd1 << 62) >> sh) / (2 * n + 1);
      if (n[0]) sum = sum - t;
      else sum = sum + t;
      n++;
      sh = sh + 2 * i;
    end
    return sum;
  endfunction

  function automatic void build_consts();
    longint unsigned quarter_pi, a, r;
    quarter_pi = 4 * atan_inv(5) - atan_inv(239);
    for (int i = 0; i < 40; i++) begin
      a = (i == 0) ? quarter_pi : atan_shift(i);
      if (a > quarter_pi) a = quarter_pi;
      r = q62_ratio(a, quarter_pi);
      atan_units[i] = (r + (64'd1 << 32)) >> 33;
    end
    r = q62_ratio(SEMI_MINOR_DMM, SEMI_MAJOR_DMM);
    axis_r2 = hi_mul_shift(r, r, 64);
  endfunction

  // length times q30 fraction, rounded half up
  function automatic longint frac_mul(longint a, longint f);
    logic signed [127:0] pa, pf, p;
    pa = a;
    pf = f;
    p  = pa * pf + 128'sd536870912;
    p  = p >>> 30;
    return p[63:0];
  endfunction

  function automatic void cordic_sincos(logic [ANG_W-1:0] ang, output longint c,
                                        output longint s);
    logic [1:0] quad;
    longint z, x, y, xs, ys;
    quad = ang[31:30];
    z    = longint'(ang[29:0]);
    if (z >= (64'sd1 << 29)) begin
      z    = z - (64'sd1 << 30);
      quad = quad + 2'd1;
    end
    x = GAIN_Q30 * 1024;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_units[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_units[i]);
      end
    end
    x = (x + 512) >>> 10;
    y = (y + 512) >>> 10;
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic void geo_to_ecef(logic [ANG_W-1:0] lat, logic [ANG_W-1:0] lon,
                                      longint h, output longint xyz [3],
                                      output longint trig [4]);
    longint cp, sp, cl, sl, t;
    longint unsigned w, sq, nrad, nb;
    cordic_sincos(lat, cp, sp);
    cordic_sincos(lon, cl, sl);
    w = longint'(cp * cp) + hi_mul_shift(axis_r2, longint'(sp * sp), 60);
    if (w > (64'd1 << 61)) w = 64'd1 << 61;
    if (w < (64'd1 << 59)) w = 64'd1 << 59;
    sq = root_floor(w << 2);
    if (sq == 0) sq = 1;
    nrad = (SEMI_MAJOR_MM << 31) / sq;
    nb   = hi_mul_shift(nrad, axis_r2, 60);
    t      = frac_mul(longint'(nrad) + h, cp);
    xyz[0] = frac_mul(t, cl);
    xyz[1] = frac_mul(t, sl);
    xyz[2] = frac_mul(longint'(nb) + h, sp);
    trig[0] = cp;
    trig[1] = sp;
    trig[2] = cl;
    trig[3] = sl;
  endfunction

  function automatic logic signed [OUT_W-1:0] clip_ofs(longint v);
    if (v > OFS_MAX) v = OFS_MAX;
    if (v < OFS_MIN) v = OFS_MIN;
    return v[OUT_W-1:0];
  endfunction

  function automatic enu_exp_t predict_enu(longint lat, longint lon, longint h, bit pv);
    enu_exp_t r;
    longint p [3], o [3], tp [4], tr [4];
    longint dx, dy, dz, proj;
    r = '{e: '0, n: '0, u: '0, rv: 1'b0};
    if (!pv || !org_valid) return r;
    geo_to_ecef(lat[31:0], lon[31:0], h, p, tp);
    geo_to_ecef(org_lat[31:0], org_lon[31:0], org_h, o, tr);
    dx   = p[0] - o[0];
    dy   = p[1] - o[1];
    dz   = p[2] - o[2];
    proj = frac_mul(dx, tr[2]) + frac_mul(dy, tr[3]);
    r.e  = clip_ofs(frac_mul(dy, tr[2]) - frac_mul(dx, tr[3]));
    r.n  = clip_ofs(frac_mul(dz, tr[0]) - frac_mul(proj, tr[1]));
    r.u  = clip_ofs(frac_mul(proj, tr[0]) + frac_mul(dz, tr[1]));
    r.rv = 1'b1;
    return r;
  endfunction

  // ---------------- stimulus ----------------

  // one point transaction, held until accepted; bursts separated by random gaps
  task automatic send_point(point_row_t row);
    enu_exp_t x;
    if (burst_left == 0) begin
      pt.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 50)
                                                : $urandom_range(12, 1);
    end
    pt.valid           <= 1'b1;
    pt.point_latitude  <= row.lat[ANG_W-1:0];
    pt.point_longitude <= row.lon[ANG_W-1:0];
    pt.point_height    <= row.h[H_W-1:0];
    pt.point_valid     <= row.pv;
    @(posedge clk_i);
    while (!pt.ready) @(posedge clk_i);
    burst_left--;
    if (row.typed) begin
      x.e  = row.e[OUT_W-1:0];
      x.n  = row.n[OUT_W-1:0];
      x.u  = row.u[OUT_W-1:0];
      x.rv = row.rv;
    end else begin
      x = predict_enu(row.lat, row.lon, row.h, row.pv);
    end
    pending_enu.push_back(x);
  endtask

  // wait for every outstanding result, then let the pipe settle
  task automatic drain();
    pt.valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_enu.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_origin(longint lat, longint lon, longint h, bit v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ORIGIN_LAT;
    cfg_data_i <= lat[CFG_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ORIGIN_LON;
    cfg_data_i <= lon[CFG_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ORIGIN_H;
    cfg_data_i <= h[CFG_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ORIGIN_VALID;
    cfg_data_i <= CFG_W'(v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    org_lat   = lat;
    org_lon   = lon;
    org_h     = h;
    org_valid = v;
  endtask

  function automatic longint rand_lat();
    return longint'($urandom_range(32'h8000_0000, 0)) - LAT_MAX;
  endfunction

  function automatic longint rand_lon();
    return longint'($signed($urandom()));
  endfunction

  function automatic longint rand_h();
    return longint'($urandom_range(50500000, 0)) + H_LOW;
  endfunction

  // mostly points around the origin, some anywhere on the globe
  task automatic random_points(int count);
    point_row_t row;
    longint span;
    for (int i = 0; i < count; i++) begin
      row = '{default: 0};
      if ($urandom_range(9, 0) < 7) begin
        span    = 64'sd1 << $urandom_range(22, 4);
        row.lat = org_lat + longint'($urandom_range(2 * span, 0)) - span;
        row.lon = org_lon + longint'($urandom_range(2 * span, 0)) - span;
        if (row.lat > LAT_MAX) row.lat = LAT_MAX;
        if (row.lat < -LAT_MAX) row.lat = -LAT_MAX;
        row.lon = longint'($signed(row.lon[31:0]));
        row.h   = ($urandom_range(1, 0) != 0) ? org_h + $urandom_range(20000, 0) - 10000
                                              : rand_h();
        if (row.h > H_HIGH) row.h = H_HIGH;
        if (row.h < H_LOW) row.h = H_LOW;
      end else begin
        row.lat = rand_lat();
        row.lon = rand_lon();
        row.h   = rand_h();
      end
      row.pv = ($urandom_range(9, 0) != 0);
      send_point(row);
    end
  endtask

  // directed rows while the origin is still undefined after reset
  point_row_t rows_no_origin [3] = '{
    '{0, 0, 0, 1, 1, 0, 0, 0, 0},
    '{1073741824, 2147483647, 50000000, 1, 1, 0, 0, 0, 0},
    '{-1073741824, -64'sd2147483648, -500000, 0, 1, 0, 0, 0, 0}
  };

  // directed rows with the origin at zero latitude, longitude and height
  point_row_t rows_zero_origin [16] = '{
    '{0, 0, 0, 1, 1, 0, 0, 0, 1},
    '{0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{1073741824, 0, 0, 1, 0, 0, 0, 0, 0},
    '{-1073741824, 0, 0, 1, 0, 0, 0, 0, 0},
    '{0, 2147483647, 0, 1, 0, 0, 0, 0, 0},
    '{0, -64'sd2147483648, 0, 1, 0, 0, 0, 0, 0},
    '{0, 1073741824, 0, 1, 0, 0, 0, 0, 0},
    '{0, -1073741824, 0, 1, 0, 0, 0, 0, 0},
    '{536870912, 536870912, 50000000, 1, 0, 0, 0, 0, 0},
    '{-536870912, -536870912, -500000, 1, 0, 0, 0, 0, 0},
    '{1, 1, 1, 1, 0, 0, 0, 0, 0},
    '{-1, -1, -1, 1, 0, 0, 0, 0, 0},
    '{0, 536870911, 0, 1, 0, 0, 0, 0, 0},
    '{1073741824, -64'sd2147483648, -500000, 1, 0, 0, 0, 0, 0},
    '{1073741823, 12345678, 1000, 1, 0, 0, 0, 0, 0},
    '{-1073741823, -87654321, 33554432, 1, 0, 0, 0, 0, 0}
  };

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_ORIGIN_LAT;
    cfg_data_i         = '0;
    pt.valid           = 1'b0;
    pt.point_latitude  = '0;
    pt.point_longitude = '0;
    pt.point_height    = '0;
    pt.point_valid     = 1'b0;
    org_lat    = 0;
    org_lon    = 0;
    org_h      = 0;
    org_valid  = 0;
    fail_cnt   = 0;
    burst_left = 0;
    build_consts();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows_no_origin[i]) send_point(rows_no_origin[i]);
    drain();
    set_origin(0, 0, 0, 1);
    foreach (rows_zero_origin[i]) send_point(rows_zero_origin[i]);
    drain();

    // random phases over a spread of origins, extremes included
    set_origin(LAT_MAX, -64'sd2147483648, H_LOW, 1);
    random_points(RAND_PER_PHASE);
    drain();
    set_origin(-LAT_MAX, 64'sd2147483647, H_HIGH, 1);
    random_points(RAND_PER_PHASE);
    drain();
    set_origin(rand_lat(), rand_lon(), rand_h(), 0);
    random_points(60);
    drain();
    for (int k = 0; k < 4; k++) begin
      set_origin(rand_lat(), rand_lon(), rand_h(), 1);
      random_points(RAND_PER_PHASE);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------- receiver ----------------

  // stall pattern: modes switch on bits 9:8 of a free-running counter, one of them never stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cnt    <= 0;
      enu.ready <= 1'b0;
    end else begin
      rx_cnt <= rx_cnt + 1;
      case (rx_cnt[9:8])
        2'd0: enu.ready <= 1'b1;
        2'd1: enu.ready <= (rx_cnt[2:0] != 3'd5);
        2'd2: enu.ready <= 1'($urandom_range(1, 0));
        default: enu.ready <= !(rx_cnt[5] && rx_cnt[3]);
      endcase
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && enu.valid && enu.ready) begin
      if (pending_enu.size() == 0) begin
        $display("%0t: unexpected result e=%0d n=%0d u=%0d v=%0b", $time,
                 enu.east_offset, enu.north_offset, enu.up_offset, enu.result_valid);
        fail_cnt++;
      end else begin
        enu_exp_t x;
        x = pending_enu.pop_front();
        if (enu.east_offset !== x.e) begin
          $display("%0t: east expected %0d actual %0d", $time, x.e, enu.east_offset);
          fail_cnt++;
        end
        if (enu.north_offset !== x.n) begin
          $display("%0t: north expected %0d actual %0d", $time, x.n, enu.north_offset);
          fail_cnt++;
        end
        if (enu.up_offset !== x.u) begin
          $display("%0t: up expected %0d actual %0d", $time, x.u, enu.up_offset);
          fail_cnt++;
        end
        if (enu.result_valid !== x.rv) begin
          $display("%0t: result_valid expected %0b actual %0b", $time, x.rv,
                   enu.result_valid);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (pt.valid && pt.ready) || (enu.valid && enu.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

[geodetic_to_enu.f]
src/gte_pkg.sv
src/gte_if.sv
src/gte_ecef.sv
src/geodetic_to_enu.sv
sim/tb_geodetic_to_enu.sv
